/* rtl/stb_pkg.sv */
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants for the software timer bank
// Slot count, field widths, command codes and the increment/compare result.
// ----------------------------------------------------------------------------
package stb_pkg;

    // Number of timer slots in the bank
    localparam int NUM_TIMERS = 8;

    // Slot index and created-slot counter widths
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    // Fixed field widths
    localparam int MODE_W  = 2;
    localparam int TIDX_W  = 3;
    localparam int VALUE_W = 32;
    localparam int MASK_W  = 8;

    // Command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_CREATE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_START  = 2'd3
    } t_mode;

    // Result of the shared increment/compare unit
    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] sum;
    } t_alu_res;

endpackage

/* rtl/stb_alu.sv */
// ----------------------------------------------------------------------------
// stb_alu: shared slot increment and expiry compare
// Adds one to a slot count (mod 2^32) and flags a match with the period.
// ----------------------------------------------------------------------------
module stb_alu
    import stb_pkg::*;
(
    input  logic [VALUE_W-1:0] i_count,
    input  logic [VALUE_W-1:0] i_period,
    output t_alu_res           o_res
);

    // Increment, then compare the new count against the period
    always_comb begin
        o_res.sum = i_count + VALUE_W'(1);
        o_res.hit = (o_res.sum == i_period);
    end

endmodule

/* rtl/software_timer_bank_unit.sv */
// Tick word: not ready after acceptance until the mask is handed off. ST_TICK walks slots
// 0 to created count minus one, one slot each through the shared unit, then ST_POST hands
// off the mask into the output register; a held mask blocks the hand-off. Other words:
// next word the cycle after.
// Reset (i_rst_n low, synchronous) stops and zeroes all slots and the created count.
// ----------------------------------------------------------------------------
// software_timer_bank_unit: bank of software timers with expiry mask
// A small sequencer walks the slots on each tick through one shared unit.
// ----------------------------------------------------------------------------
module software_timer_bank_unit
    import stb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [TIDX_W-1:0]   i_timer_index,
    input  logic                i_start_running,
    input  logic                i_auto_reload,
    input  logic [VALUE_W-1:0]  i_initial_count,
    input  logic [VALUE_W-1:0]  i_expiry_period,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [MASK_W-1:0]   o_expired_mask
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_POST
    } t_state;

    t_state r_state, n_state;

    // Slot storage
    logic [NUM_TIMERS-1:0] r_running, n_running;
    logic [NUM_TIMERS-1:0] r_reload, n_reload;
    logic [VALUE_W-1:0]    r_count [NUM_TIMERS];
    logic [VALUE_W-1:0]    r_period [NUM_TIMERS];

    logic [CNT_W-1:0]  r_created, n_created;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_last, n_last;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic              r_out_valid, n_out_valid;
    logic [MASK_W-1:0] r_out_mask, n_out_mask;

    logic              in_acc;
    logic              cmd_ok;
    logic [IDX_W-1:0]  cmd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [VALUE_W-1:0] wr_count;
    logic              wr_period_en;
    t_alu_res          alu_res;

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_expired_mask = r_out_mask;
    assign in_acc         = i_in_valid && o_in_ready;
    assign cmd_ok         = (32'(i_timer_index) < 32'(NUM_TIMERS));
    assign cmd_idx        = IDX_W'(i_timer_index);

    // Shared increment/compare on the slot under the sequencer
    stb_alu u_alu (
        .i_count  (r_count[r_idx]),
        .i_period (r_period[r_idx]),
        .o_res    (alu_res)
    );

    // Sequencer and command decode
    always_comb begin
        n_state      = r_state;
        n_running    = r_running;
        n_reload     = r_reload;
        n_created    = r_created;
        n_idx        = r_idx;
        n_last       = r_last;
        n_mask       = r_mask;
        n_out_valid  = r_out_valid;
        n_out_mask   = r_out_mask;
        wr_en        = 1'b0;
        wr_idx       = cmd_idx;
        wr_count     = i_initial_count;
        wr_period_en = 1'b0;

        // Output register drains independently
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_mode'(i_mode))
                        MODE_TICK: begin
                            n_idx  = '0;
                            n_mask = '0;
                            n_last = r_created - CNT_W'(1);
                            n_state = (r_created == '0) ? ST_POST : ST_TICK;
                        end
                        MODE_CREATE: begin
                            if (cmd_ok) begin
                                n_running[cmd_idx] = i_start_running;
                                n_reload[cmd_idx]  = i_auto_reload;
                                wr_en        = 1'b1;
                                wr_period_en = 1'b1;
                                if (32'(r_created) < 32'(NUM_TIMERS)) begin
                                    n_created = r_created + CNT_W'(1);
                                end
                            end
                        end
                        MODE_CLEAR: begin
                            if (cmd_ok) begin
                                wr_en    = 1'b1;
                                wr_count = '0;
                            end
                        end
                        MODE_START: begin
                            if (cmd_ok) begin
                                n_running[cmd_idx] = 1'b1;
                                n_reload[cmd_idx]  = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TICK: begin
                // One slot per cycle
                if (r_running[r_idx]) begin
                    wr_en    = 1'b1;
                    wr_idx   = r_idx;
                    wr_count = alu_res.hit ? '0 : alu_res.sum;
                    if (alu_res.hit) begin
                        n_running[r_idx] = r_reload[r_idx];
                        if (32'(r_idx) < 32'(MASK_W)) begin
                            n_mask = r_mask | (MASK_W'(1) << r_idx);
                        end
                    end
                end
                if (CNT_W'(r_idx) == r_last) begin
                    n_state = ST_POST;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_POST: begin
                // Hand the mask over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_mask  = r_mask;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_running   <= '0;
            r_reload    <= '0;
            r_created   <= '0;
            r_idx       <= '0;
            r_last      <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
            r_out_mask  <= '0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_reload    <= n_reload;
            r_created   <= n_created;
            r_idx       <= n_idx;
            r_last      <= n_last;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
            r_out_mask  <= n_out_mask;
        end
    end

    // Slot count and period storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_count[k]  <= '0;
                r_period[k] <= '0;
            end
        end else begin
            if (wr_en) begin
                r_count[wr_idx] <= wr_count;
            end
            if (wr_period_en) begin
                r_period[wr_idx] <= i_expiry_period;
            end
        end
    end

endmodule

/* rtl/stb_checker.sv */
// ----------------------------------------------------------------------------
// stb_checker: port-level checks for the software timer bank
// Watches the handshakes and busy behavior seen on the top-level ports.
// ----------------------------------------------------------------------------
module stb_checker
    import stb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [MASK_W-1:0]   o_expired_mask
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // No result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    // A tick word makes the bank busy
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == MODE_TICK) |=> !o_in_ready)
        else $error("ready right after tick word");

    // Slot commands complete at acceptance
    a_cmd_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode != MODE_TICK) |=> o_in_ready)
        else $error("busy after slot command word");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_expired_mask)))
        else $error("result word dropped or changed while stalled");

endmodule

bind software_timer_bank_unit stb_checker u_stb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_mode         (i_mode),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_expired_mask (o_expired_mask)
);
